FILE: rtl/core/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, character codes and byte classes for the token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [15:0]              LINE_MAX = 16'hFFFF;

  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_DEC    = 4'd1;
  localparam logic [3:0] KIND_HEX    = 4'd2;
  localparam logic [3:0] KIND_BIN    = 4'd3;
  localparam logic [3:0] KIND_OCT    = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_COLON  = 4'd6;
  localparam logic [3:0] KIND_LPAREN = 4'd7;
  localparam logic [3:0] KIND_RPAREN = 4'd8;
  localparam logic [3:0] KIND_EOF    = 4'd9;
  localparam logic [3:0] KIND_ERROR  = 4'd10;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] stop;
    logic [15:0] line;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_bin(input logic [7:0] c);
    return (c == CH_ZERO) || (c == CH_ONE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_identc(input logic [7:0] c);
    return is_letter(c) || is_dec(c) || (c == CH_UNDER);
  endfunction

endpackage

FILE: rtl/core/atl_scan.sv
// ----------------------------------------------------------------------------
// atl_scan
// Byte register, scan state and token decode; pushes up to two tokens a byte.
// ----------------------------------------------------------------------------
module atl_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    text_byte,
  input  logic          room,
  output atl_pkg::push_t push
);
  import atl_pkg::*;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_DEC     = 4'd2;
  localparam logic [3:0] M_MINUS   = 4'd3;
  localparam logic [3:0] M_ZERO    = 4'd4;
  localparam logic [3:0] M_OCT     = 4'd5;
  localparam logic [3:0] M_HEXPRE  = 4'd6;
  localparam logic [3:0] M_HEX     = 4'd7;
  localparam logic [3:0] M_BINPRE  = 4'd8;
  localparam logic [3:0] M_BIN     = 4'd9;
  localparam logic [3:0] M_COMMENT = 4'd10;

  logic [7:0]               byte_q;
  logic                     byte_valid;
  logic [3:0]               mode;
  logic [3:0]               mode_next;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] pos_end;
  logic [POSITION_BITS-1:0] tstart;
  logic [POSITION_BITS-1:0] tstart_next;
  logic [15:0]              line;
  logic [15:0]              line_next;
  logic                     fire;
  logic                     again;
  logic                     eof;
  logic                     emit_a;
  logic                     emit_b;
  logic [3:0]               kind_a;
  logic [3:0]               kind_b;
  token_t                   tok_a;
  token_t                   tok_b;

  assign fire     = byte_valid && room;
  assign in_ready = !byte_valid || fire;
  assign pos_end  = (pos != POS_MAX) ? pos + 1'b1 : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_q <= text_byte;
    end
  end

  always_comb begin
    mode_next   = mode;
    emit_a      = 1'b0;
    kind_a      = KIND_ERROR;
    again       = 1'b0;
    tstart_next = tstart;
    line_next   = line;
    emit_b      = 1'b0;
    kind_b      = KIND_ERROR;
    eof         = 1'b0;
    // close or extend the open token
    unique case (mode)
      M_IDENT: begin
        if (!is_identc(byte_q)) begin
          emit_a = 1'b1; kind_a = KIND_IDENT; again = 1'b1;
        end
      end
      M_DEC: begin
        if (!is_dec(byte_q)) begin
          emit_a = 1'b1; kind_a = KIND_DEC; again = 1'b1;
        end
      end
      M_MINUS: begin
        if (byte_q == CH_ZERO) begin
          mode_next = M_ZERO;
        end else if (is_dec(byte_q)) begin
          mode_next = M_DEC;
        end else begin
          emit_a = 1'b1; kind_a = KIND_ERROR; again = 1'b1;
        end
      end
      M_ZERO: begin
        if (byte_q == CH_LO_X) begin
          mode_next = M_HEXPRE;
        end else if (byte_q == CH_LO_B) begin
          mode_next = M_BINPRE;
        end else if (is_oct(byte_q)) begin
          mode_next = M_OCT;
        end else begin
          emit_a = 1'b1; kind_a = KIND_OCT; again = 1'b1;
        end
      end
      M_OCT: begin
        if (!is_oct(byte_q)) begin
          emit_a = 1'b1; kind_a = KIND_OCT; again = 1'b1;
        end
      end
      M_HEXPRE: begin
        if (is_hex(byte_q)) begin
          mode_next = M_HEX;
        end else begin
          emit_a = 1'b1; kind_a = KIND_ERROR; again = 1'b1;
        end
      end
      M_HEX: begin
        if (!is_hex(byte_q)) begin
          emit_a = 1'b1; kind_a = KIND_HEX; again = 1'b1;
        end
      end
      M_BINPRE: begin
        if (is_bin(byte_q)) begin
          mode_next = M_BIN;
        end else begin
          emit_a = 1'b1; kind_a = KIND_ERROR; again = 1'b1;
        end
      end
      M_BIN: begin
        if (!is_bin(byte_q)) begin
          emit_a = 1'b1; kind_a = KIND_BIN; again = 1'b1;
        end
      end
      M_COMMENT: begin
        if ((byte_q == CH_LF) || (byte_q == CH_NUL)) begin
          again = 1'b1;
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase
    // scan the byte between tokens
    if (again) begin
      mode_next = M_IDLE;
      priority if (byte_q == CH_LF) begin
        if (line != LINE_MAX) begin
          line_next = line + 16'd1;
        end
      end else if ((byte_q == CH_SPACE) || (byte_q == CH_TAB)) begin
        tstart_next = tstart;
      end else if (is_letter(byte_q) || (byte_q == CH_UNDER)) begin
        tstart_next = pos; mode_next = M_IDENT;
      end else if (byte_q == CH_MINUS) begin
        tstart_next = pos; mode_next = M_MINUS;
      end else if (byte_q == CH_ZERO) begin
        tstart_next = pos; mode_next = M_ZERO;
      end else if (is_dec(byte_q)) begin
        tstart_next = pos; mode_next = M_DEC;
      end else if (byte_q == CH_SEMI) begin
        mode_next = M_COMMENT;
      end else if (byte_q == CH_COMMA) begin
        emit_b = 1'b1; kind_b = KIND_COMMA;
      end else if (byte_q == CH_COLON) begin
        emit_b = 1'b1; kind_b = KIND_COLON;
      end else if (byte_q == CH_LPAREN) begin
        emit_b = 1'b1; kind_b = KIND_LPAREN;
      end else if (byte_q == CH_RPAREN) begin
        emit_b = 1'b1; kind_b = KIND_RPAREN;
      end else if (byte_q == CH_NUL) begin
        emit_b = 1'b1; kind_b = KIND_EOF; eof = 1'b1;
      end else begin
        emit_b = 1'b1; kind_b = KIND_ERROR;
      end
    end
  end

  always_comb begin
    tok_a.kind  = kind_a;
    tok_a.start = 16'(tstart);
    tok_a.stop  = 16'(pos);
    tok_a.line  = line;
    tok_a.last  = !emit_b;
    tok_b.kind  = kind_b;
    tok_b.start = 16'(pos);
    tok_b.stop  = 16'(pos_end);
    tok_b.line  = line;
    tok_b.last  = 1'b1;
    push.tok0   = emit_a ? tok_a : tok_b;
    push.tok1   = tok_b;
    push.count  = fire ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      line   <= 16'd1;
    end else if (fire) begin
      if (eof) begin
        mode   <= M_IDLE;
        pos    <= '0;
        tstart <= '0;
        line   <= 16'd1;
      end else begin
        mode   <= mode_next;
        pos    <= pos_end;
        tstart <= tstart_next;
        line   <= line_next;
      end
    end
  end

endmodule

FILE: rtl/core/atl_fifo.sv
// ----------------------------------------------------------------------------
// atl_fifo
// Token queue: takes up to two tokens a cycle, hands out one a transaction.
// ----------------------------------------------------------------------------
module atl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  atl_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output atl_pkg::token_t head
);
  import atl_pkg::*;

  token_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("token queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= FIFO_CW'(FIFO_DEPTH - 2)))
    else $error("token push without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && (push.count == 2'd0)) |=> (count == $past(count) - 1'b1))
    else $error("token queue count did not drop after pop");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (!pop && (push.count == 2'd2)) |=> (count == $past(count) + 2'd2))
    else $error("token queue count did not grow after double push");
`endif

endmodule

FILE: rtl/core/assembly_token_lexer.sv
// ----------------------------------------------------------------------------
// assembly_token_lexer
// Assembly source lexer: one text byte per transaction in, one token out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries text_byte; byte 0 ends the text.
// Output channel out_valid/out_ready carries one token per transaction:
// token_kind, span_start, span_end (exclusive), line_number, and last_of_run,
// set on the final token a byte produces (a byte yields zero to two tokens).
// A byte is scanned out of the input register in the cycle after it is taken
// and its tokens enter a four-entry queue once the queue has room; the
// head of the queue drives the output channel, so a token is offered as soon
// as it is written into the queue. One byte is taken per cycle as long as
// the queue has two free entries, so the output side sets the rate when
// bytes produce more than one token per cycle on average.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost. Reset (rst, synchronous) empties the queue and returns the scanner to
// offset 0, line 1; the end-of-text token does the same for the scanner.
// ----------------------------------------------------------------------------
module assembly_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] span_start,
  output logic [15:0] span_end,
  output logic [15:0] line_number,
  output logic        last_of_run
);
  import atl_pkg::*;

  push_t  push;
  token_t head;
  logic   room;

  atl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .room      (room),
    .push      (push)
  );

  atl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign token_kind  = head.kind;
  assign span_start  = head.start;
  assign span_end    = head.stop;
  assign line_number = head.line;
  assign last_of_run = head.last;

endmodule
